[rtl/midpoint_circle_rasterizer_assert.svh]
// Assertion macros used by the circle rasterizer top level.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define MCR_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MCR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

[rtl/mcr_pkg.sv]
// Shared types and constants of the circle rasterizer.
`default_nettype none
package mcr_pkg;

    localparam int X_W   = 11;
    localparam int D_W   = 16;
    localparam int C_W   = 12;
    localparam int COL_W = 24;
    localparam int R_W   = 10;
    localparam int P_W   = 13;
    localparam int PT_W  = 14;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // One word of work for the point emitter.
    typedef struct packed {
        logic                    empty;
        logic        [X_W-1:0]   x;
        logic signed [X_W-1:0]   y;
        logic signed [C_W-1:0]   cx;
        logic signed [C_W-1:0]   cy;
        logic        [COL_W-1:0] color;
        logic                    more;
    } t_job;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } t_emit_stat;

endpackage
`default_nettype wire

[rtl/midpoint_circle_rasterizer.sv]
// Midpoint circle rasterizer: top level.
//
// Input channel (i_valid / o_stall): a word with action 0 starts a circle from
// its center, radius and color; action 1 advances the running circle one step.
// Output channel (o_valid / i_stall): one pixel word per cycle while i_stall is
// low and a job is held. A start or a live step gives eight mirrored points, the
// last flagged by o_last_of_item; a step with no live circle gives one all-zero
// word with o_last_of_item set. A word is held in the job register, and its
// points leave through the single output register, one point per cycle while
// i_stall is low. The next word is taken in the cycle the last point of the
// previous one leaves the job register, so points stream without gaps.
// Reset clears the circle state and empties the job and output registers.
// While i_stall is high the output word holds, the job stops advancing and
// o_stall rises once the job register is full.
`default_nettype none
`include "midpoint_circle_rasterizer_assert.svh"
module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int SCREEN_W = 512,
    parameter int SCREEN_H = 256
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_action,
    input  wire logic signed [C_W-1:0]   i_center_x,
    input  wire logic signed [C_W-1:0]   i_center_y,
    input  wire logic        [R_W-1:0]   i_radius,
    input  wire logic        [COL_W-1:0] i_color,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [P_W-1:0]        o_pixel_x,
    output logic signed [P_W-1:0]        o_pixel_y,
    output logic        [COL_W-1:0]      o_pixel_color,
    output logic                         o_on_screen,
    output logic                         o_last_of_item,
    output logic                         o_more_steps
);

    t_job       job;
    t_emit_stat stat;
    logic       load_ok;
    logic       accept;

    assign o_stall = !load_ok;
    assign accept  = i_valid && load_ok;

    mcr_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .o_job      (job)
    );

    mcr_emit #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_job          (job),
        .o_load_ok      (load_ok),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_on_screen    (o_on_screen),
        .o_last_of_item (o_last_of_item),
        .o_more_steps   (o_more_steps)
    );

    `MCR_ASSERT_NEXT(a_accept_loads_job, accept, stat.busy && stat.idx == '0, "accepted word did not load the job register")
    `MCR_ASSERT_NOW(a_mid_point_has_job, o_valid && !o_last_of_item, stat.busy, "point word shown without a job to finish it")
    `MCR_ASSERT_NOW(a_idle_takes_input, !stat.busy, !o_stall, "idle emitter stalls the input")

endmodule
`default_nettype wire

[rtl/mcr_step.sv]
// Circle state registers and the midpoint update for one accepted word.
`default_nettype none
module mcr_step
    import mcr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire logic                    i_action,
    input  wire logic signed [C_W-1:0]   i_center_x,
    input  wire logic signed [C_W-1:0]   i_center_y,
    input  wire logic        [R_W-1:0]   i_radius,
    input  wire logic        [COL_W-1:0] i_color,
    output t_job                         o_job
);

    logic                    r_active;
    logic        [X_W-1:0]   r_x;
    logic signed [X_W-1:0]   r_y;
    logic signed [D_W-1:0]   r_d;
    logic signed [C_W-1:0]   r_cx;
    logic signed [C_W-1:0]   r_cy;
    logic        [COL_W-1:0] r_color;

    logic                    n_active;
    logic        [X_W-1:0]   n_x;
    logic signed [X_W-1:0]   n_y;
    logic signed [D_W-1:0]   n_d;
    logic signed [C_W-1:0]   n_cx;
    logic signed [C_W-1:0]   n_cy;
    logic        [COL_W-1:0] n_color;

    logic                    finished;
    logic        [X_W-1:0]   x_inc;
    logic signed [X_W-1:0]   y_dec;
    logic        [D_W-1:0]   x_inc_w;
    logic        [D_W-1:0]   diff_w;
    logic                    empty;

    assign finished = $signed({r_y[X_W-1], r_y}) < $signed({1'b0, r_x});
    assign x_inc    = r_x + X_W'(1);
    assign y_dec    = r_y - X_W'(1);
    assign x_inc_w  = {{(D_W-X_W){1'b0}}, x_inc};
    assign diff_w   = x_inc_w - {{(D_W-X_W){y_dec[X_W-1]}}, y_dec};

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_color  = r_color;
        empty    = 1'b0;
        if (i_action == ACT_START) begin
            n_active = 1'b1;
            n_x      = '0;
            n_y      = $signed({1'b0, i_radius});
            n_d      = $signed(D_W'(3) - {{(D_W-R_W-1){1'b0}}, i_radius, 1'b0});
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_color  = i_color;
        end else if (!r_active || finished) begin
            n_active = 1'b0;
            empty    = 1'b1;
        end else begin
            n_x = x_inc;
            if (r_d > 0) begin
                n_y = y_dec;
                n_d = $signed(r_d + D_W'({diff_w, 2'b00}) + D_W'(10));
            end else begin
                n_d = $signed(r_d + D_W'({x_inc_w, 2'b00}) + D_W'(6));
            end
        end
    end

    always_comb begin
        o_job.empty = empty;
        o_job.x     = n_x;
        o_job.y     = n_y;
        o_job.cx    = n_cx;
        o_job.cy    = n_cy;
        o_job.color = n_color;
        o_job.more  = $signed({n_y[X_W-1], n_y}) >= $signed({1'b0, n_x});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_color  <= '0;
        end else if (i_accept) begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_color  <= n_color;
        end
    end

endmodule
`default_nettype wire

[rtl/mcr_emit.sv]
// Job register, octant point generation, clipping and the output register.
`default_nettype none
module mcr_emit
    import mcr_pkg::*;
#(
    parameter int SCREEN_W = 512,
    parameter int SCREEN_H = 256
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  t_job                         i_job,
    output logic                         o_load_ok,
    output t_emit_stat                   o_stat,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [P_W-1:0]        o_pixel_x,
    output logic signed [P_W-1:0]        o_pixel_y,
    output logic        [COL_W-1:0]      o_pixel_color,
    output logic                         o_on_screen,
    output logic                         o_last_of_item,
    output logic                         o_more_steps
);

    t_job             r_job;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_valid;

    logic                   can_adv;
    logic                   last_pt;
    logic                   job_done;
    logic signed [PT_W-1:0] xa;
    logic signed [PT_W-1:0] yb;
    logic signed [PT_W-1:0] oa;
    logic signed [PT_W-1:0] ob;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   on;

    assign can_adv   = !r_valid || !i_stall;
    assign last_pt   = r_job.empty || (r_idx == IDX_LAST);
    assign job_done  = r_busy && can_adv && last_pt;
    assign o_load_ok = !r_busy || job_done;
    assign o_valid   = r_valid;

    always_comb begin
        o_stat.busy = r_busy;
        o_stat.idx  = r_idx;
    end

    // Index bit 2 swaps the roles of x and y; bits 0 and 1 mirror each axis.
    always_comb begin
        xa = $signed({{(PT_W-X_W){1'b0}}, r_job.x});
        yb = $signed({{(PT_W-X_W){r_job.y[X_W-1]}}, r_job.y});
        oa = r_idx[2] ? yb : xa;
        ob = r_idx[2] ? xa : yb;
        px = $signed({{(PT_W-C_W){r_job.cx[C_W-1]}}, r_job.cx}) + (r_idx[0] ? -oa : oa);
        py = $signed({{(PT_W-C_W){r_job.cy[C_W-1]}}, r_job.cy}) + (r_idx[1] ? -ob : ob);
        on = (px >= 0) && (px < $signed(PT_W'(SCREEN_W)))
            && (py >= 0) && (py < $signed(PT_W'(SCREEN_H)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (job_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && can_adv) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_adv) begin
            r_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_adv && r_busy) begin
            o_last_of_item <= last_pt;
            if (r_job.empty) begin
                o_pixel_x     <= '0;
                o_pixel_y     <= '0;
                o_pixel_color <= '0;
                o_on_screen   <= 1'b0;
                o_more_steps  <= 1'b0;
            end else begin
                o_pixel_x     <= px[P_W-1:0];
                o_pixel_y     <= py[P_W-1:0];
                o_pixel_color <= r_job.color;
                o_on_screen   <= on;
                o_more_steps  <= r_job.more;
            end
        end
    end

endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the midpoint circle rasterizer.
`timescale 1ns / 1ps
module tb;
    import mcr_pkg::*;

    localparam int SCREEN_W    = 512;
    localparam int SCREEN_H    = 256;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic signed [P_W-1:0]   px;
        logic signed [P_W-1:0]   py;
        logic        [COL_W-1:0] color;
        logic                    on_screen;
        logic                    last;
        logic                    more;
    } t_pixel;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_action = ACT_STEP;
    logic signed [C_W-1:0]   in_center_x = '0;
    logic signed [C_W-1:0]   in_center_y = '0;
    logic        [R_W-1:0]   in_radius = '0;
    logic        [COL_W-1:0] in_color = '0;
    logic                    res_stall = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [P_W-1:0]   o_pixel_x;
    logic signed [P_W-1:0]   o_pixel_y;
    logic        [COL_W-1:0] o_pixel_color;
    logic                    o_on_screen;
    logic                    o_last_of_item;
    logic                    o_more_steps;

    // Predicted circle state.
    logic                    drawing = 1'b0;
    logic        [X_W-1:0]   walk_x = '0;
    logic signed [X_W-1:0]   walk_y = '0;
    logic signed [D_W-1:0]   err_d = '0;
    logic signed [C_W-1:0]   org_x = '0;
    logic signed [C_W-1:0]   org_y = '0;
    logic        [COL_W-1:0] pen_color = '0;

    t_pixel pending_pixels[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     idle_on = 1'b1;
    bit     hold_req = 1'b0;

    midpoint_circle_rasterizer #(
        .SCREEN_W(SCREEN_W),
        .SCREEN_H(SCREEN_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .o_stall       (o_stall),
        .i_action      (in_action),
        .i_center_x    (in_center_x),
        .i_center_y    (in_center_y),
        .i_radius      (in_radius),
        .i_color       (in_color),
        .o_valid       (o_valid),
        .i_stall       (res_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_on_screen   (o_on_screen),
        .o_last_of_item(o_last_of_item),
        .o_more_steps  (o_more_steps)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Queue the eight mirrored points of the current (x, y).
    task automatic push_octants();
        int     xi, yi, ox, oy, a, b, px, py;
        t_pixel p;
        xi = int'(walk_x);
        yi = int'(walk_y);
        ox = int'(org_x);
        oy = int'(org_y);
        for (int k = 0; k < 8; k++) begin
            a = (k < 4) ? xi : yi;
            b = (k < 4) ? yi : xi;
            px = ox + ((k & 1) ? -a : a);
            py = oy + ((k & 2) ? -b : b);
            p.px = px[P_W-1:0];
            p.py = py[P_W-1:0];
            p.color = pen_color;
            p.on_screen = px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H;
            p.last = (k == 7);
            p.more = yi >= xi;
            pending_pixels.push_back(p);
        end
    endtask

    task automatic predict_pixels(input logic act, input logic signed [C_W-1:0] cx,
                                  input logic signed [C_W-1:0] cy, input logic [R_W-1:0] r,
                                  input logic [COL_W-1:0] col);
        int     xi, yi, di;
        t_pixel p;
        xi = int'(walk_x);
        yi = int'(walk_y);
        di = int'(err_d);
        if (act == ACT_START) begin
            org_x = cx;
            org_y = cy;
            pen_color = col;
            walk_x = '0;
            walk_y = X_W'(r);
            di = 3 - 2 * int'(r);
            err_d = di[D_W-1:0];
            drawing = 1'b1;
            push_octants();
        end else if (!drawing || yi < xi) begin
            // Nothing left to draw: a single empty closing word.
            drawing = 1'b0;
            p = '0;
            p.last = 1'b1;
            pending_pixels.push_back(p);
        end else begin
            xi = xi + 1;
            if (di > 0) begin
                yi = yi - 1;
                di = di + 4 * (xi - yi) + 10;
            end else begin
                di = di + 4 * xi + 6;
            end
            walk_x = xi[X_W-1:0];
            walk_y = yi[X_W-1:0];
            err_d = di[D_W-1:0];
            push_octants();
        end
    endtask

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input logic act, input logic signed [C_W-1:0] cx,
                             input logic signed [C_W-1:0] cy, input logic [R_W-1:0] r,
                             input logic [COL_W-1:0] col);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_center_x <= cx;
        in_center_y <= cy;
        in_radius <= r;
        in_color <= col;
        do @(posedge i_clk); while (o_stall);
        predict_pixels(act, cx, cy, r, col);
    endtask

    task automatic send_start(input int cx, input int cy, input int r,
                              input logic [COL_W-1:0] col);
        send_word(ACT_START, C_W'(cx), C_W'(cy), R_W'(r), col);
    endtask

    // Center, radius and color are ignored on a step, so they carry noise.
    task automatic send_step();
        send_word(ACT_STEP, C_W'($urandom), C_W'($urandom), R_W'($urandom),
                  COL_W'($urandom));
    endtask

    task automatic wait_for_pixels();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, what);
    endtask

    // Receiver: a random pause after each word, or a long hold on request.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                res_stall <= 1'b0;
            end else if (i_rst_n && o_valid && !res_stall) begin
                n = idle_on ? $urandom_range(0, 3) : 0;
                if (n > 0) begin
                    res_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    res_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !res_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel word with none expected: x=%0d y=%0d",
                                          o_pixel_x, o_pixel_y));
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_x !== want.px || o_pixel_y !== want.py
                        || o_pixel_color !== want.color || o_on_screen !== want.on_screen
                        || o_last_of_item !== want.last || o_more_steps !== want.more) begin
                    report_mismatch($sformatf(
                        "pixel exp x=%0d y=%0d c=%h on=%b last=%b more=%b, got %0d %0d %h %b %b %b",
                        want.px, want.py, want.color, want.on_screen, want.last, want.more,
                        o_pixel_x, o_pixel_y, o_pixel_color, o_on_screen, o_last_of_item,
                        o_more_steps));
                end
            end
        end
    end

    task automatic test_idle_step();
        send_step();
        send_step();
    endtask

    // Radius zero draws the center eight times, then one step to x = 1, y = -1, then two empty steps.
    task automatic test_zero_radius();
        send_start(100, 50, 0, 24'h3c9e51);
        repeat (3) send_step();
    endtask

    // Field extremes, and new circles started over running ones.
    task automatic test_extremes();
        send_start(-2048, -2048, 1023, 24'hffffff);
        repeat (2) send_step();
        send_start(2047, 2047, 1023, 24'h000000);
        send_step();
        send_start(0, 0, 5, 24'ha5a5a5);
        repeat (6) send_step();
    endtask

    task automatic test_screen_edges();
        send_start(SCREEN_W - 1, SCREEN_H - 1, 1, 24'h5a5a5a);
        repeat (3) send_step();
    endtask

    task automatic test_random_circles(input int n_words);
        int sent;
        int rad;
        int n_steps;
        int ox;
        int oy;
        sent = 0;
        while (sent < n_words) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                ox = $urandom;
                oy = $urandom;
            end else begin
                ox = $urandom_range(0, SCREEN_W + 40) - 20;
                oy = $urandom_range(0, SCREEN_H + 40) - 20;
            end
            rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
            send_start(ox, oy, rad, COL_W'($urandom));
            // Enough steps to close a small circle; some are cut short or overrun.
            n_steps = (rad > 24) ? $urandom_range(1, 8) : rad * 3 / 4 + 2;
            if ($urandom_range(0, 3) == 0) n_steps = $urandom_range(0, n_steps + 2);
            repeat (n_steps) send_step();
            sent += n_steps + 1;
        end
        idle_on = 1'b1;
    endtask

    // The receiver holds off while words keep coming, so the block must stall
    // its input; then the sender waits for the pipeline to drain.
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_req = 1'b1;
        send_start(200, 100, 12, 24'h00ff00);
        repeat (7) send_step();
        wait_for_pixels();
        idle_on = 1'b1;
        send_start(-3, 250, 9, 24'h123456);
        repeat (9) send_step();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_step();
        test_zero_radius();
        test_extremes();
        test_screen_edges();
        test_random_circles(110);
        test_backpressure();
        wait_for_pixels();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mcr_pkg.sv
rtl/mcr_step.sv
rtl/mcr_emit.sv
rtl/midpoint_circle_rasterizer.sv
dv/tb.sv
